[rtl/ttlc_pkg.sv]
// Package for the TTL card cache: command codes, controller states and
// field widths. No dependencies; imported by ttl_card_cache.
package ttlc_pkg;

    localparam int unsigned UID_W      = 56;
    localparam int unsigned FLAGS_W    = 2;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned IDX_W      = 8;
    localparam int unsigned CAPACITY_D = 16;
    localparam logic [TIME_W-1:0] TTL_RESET = 32'd60000;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_PURGE  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RDREQ,
        ST_FINISH
    } t_state;

endpackage

[rtl/ttl_card_cache.sv]
// TTL card cache top level: entry store in two synchronous memories with
// a scan/modify/write-back controller. Depends on ttlc_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command per transfer:
//   lookup, insert, purge all, or read entry by index. Each command gives
//   exactly one result on the output channel (o_out_valid / i_out_ready).
//   The config channel (i_cfg_valid / o_cfg_ready) writes time_to_live; it is
//   always ready and should only be used while the block is idle.
//   Lookup and insert scan every entry once through the memory read port,
//   one entry per cycle with a registered read, then load their result in
//   the finish state. Read by index passes the read request state first;
//   purge goes straight to finish. One command is worked on at a time;
//   the next is taken once the previous result sits in the output register.
//   Reset clears the per-entry valid bits at once, so every entry reads as
//   zero straight after reset; no clearing pass. Purge clears all expiry
//   valid bits at once.
//   If the receiver stalls, the result is held in the output register and
//   a finished command waits (with its write-back) until the register frees.
module ttl_card_cache
    import ttlc_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_D
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [TIME_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_cmd,
    input  logic [TIME_W-1:0]    i_now,
    input  logic [UID_W-1:0]     i_card_uid,
    input  logic [FLAGS_W-1:0]   i_card_flags,
    input  logic [IDX_W-1:0]     i_entry_index,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_hit,
    output logic [UID_W-1:0]     o_out_uid,
    output logic [FLAGS_W-1:0]   o_out_flags,
    output logic                 o_index_out_of_range
);

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam int unsigned CARD_W = UID_W + FLAGS_W;

    // storage
    logic [CARD_W-1:0] mem_card [CAPACITY];
    logic [TIME_W-1:0] mem_exp  [CAPACITY];
    logic [CAPACITY-1:0] r_card_vld;
    logic [CAPACITY-1:0] r_exp_vld;

    // control and captured command
    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [TIME_W-1:0]  r_ttl;
    logic [TIME_W-1:0]  r_now;
    logic [UID_W-1:0]   r_uid;
    logic [FLAGS_W-1:0] r_flags;
    logic [IDX_W-1:0]   r_eidx;
    logic               r_in_range;

    // read side
    logic [CW-1:0]     r_addr;
    logic              r_rd_v;
    logic [IW-1:0]     r_rd_idx;
    logic [CARD_W-1:0] r_q_card;
    logic [TIME_W-1:0] r_q_exp;
    logic              r_q_cv;
    logic              r_q_ev;

    // scan results
    logic               r_found;
    logic [IW-1:0]      r_hit_idx;
    logic [UID_W-1:0]   r_hit_uid;
    logic [FLAGS_W-1:0] r_hit_flags;
    logic               r_free_f;
    logic [IW-1:0]      r_free_idx;
    logic [TIME_W-1:0]  r_min_exp;
    logic [IW-1:0]      r_min_idx;

    // output register
    logic               r_out_valid;
    logic               r_o_hit;
    logic [UID_W-1:0]   r_o_uid;
    logic [FLAGS_W-1:0] r_o_flags;
    logic               r_o_oor;

    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_finish;
    logic               w_rd_en;
    logic [IW-1:0]      w_raddr;
    logic               w_card_we;
    logic               w_exp_we;
    logic [IW-1:0]      w_widx;
    logic [TIME_W-1:0]  w_renewed;
    logic [CARD_W-1:0]  w_card;
    logic [TIME_W-1:0]  w_exp;
    logic               w_live;
    logic               w_match;
    logic               w_n_hit;
    logic [UID_W-1:0]   w_n_uid;
    logic [FLAGS_W-1:0] w_n_flags;
    logic               w_n_oor;
    logic               w_purge;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_finish    = (r_state == ST_FINISH) && w_out_free;
    assign w_renewed   = r_now + r_ttl;

    // entries never written read as zero
    assign w_card  = r_q_cv ? r_q_card : '0;
    assign w_exp   = r_q_ev ? r_q_exp : '0;
    assign w_live  = (w_exp >= r_now);
    assign w_match = w_live && (w_card[CARD_W-1:FLAGS_W] == r_uid);

    always_comb begin
        n_state   = r_state;
        w_rd_en   = 1'b0;
        w_raddr   = r_addr[IW-1:0];
        w_card_we = 1'b0;
        w_exp_we  = 1'b0;
        w_widx    = r_hit_idx;
        w_purge   = 1'b0;
        w_n_hit   = 1'b0;
        w_n_uid   = '0;
        w_n_flags = '0;
        w_n_oor   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_LOOKUP, CMD_INSERT: n_state = ST_SCAN;
                        CMD_PURGE:              n_state = ST_FINISH;
                        CMD_READ:               n_state = ST_RDREQ;
                        default:                n_state = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN: begin
                w_rd_en = (r_addr < CW'(CAPACITY));
                if (r_rd_v && (r_rd_idx == LAST_IDX)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_RDREQ: begin
                w_rd_en = r_in_range;
                w_raddr = r_eidx[IW-1:0];
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                unique case (r_cmd)
                    CMD_LOOKUP, CMD_INSERT: begin
                        if (r_found) begin
                            w_exp_we  = w_finish;
                            w_n_hit   = 1'b1;
                            w_n_uid   = r_hit_uid;
                            w_n_flags = r_hit_flags;
                        end else if (r_cmd == CMD_INSERT) begin
                            w_exp_we  = w_finish;
                            w_card_we = w_finish;
                            w_widx    = r_free_f ? r_free_idx : r_min_idx;
                        end
                    end
                    CMD_PURGE: w_purge = w_finish;
                    CMD_READ: begin
                        if (r_in_range) begin
                            w_n_uid   = w_card[CARD_W-1:FLAGS_W];
                            w_n_flags = w_card[FLAGS_W-1:0];
                        end else begin
                            w_n_oor = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_card_we) begin
            mem_card[w_widx] <= {r_uid, r_flags};
        end
        if (w_rd_en) begin
            r_q_card <= mem_card[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exp_we) begin
            mem_exp[w_widx] <= w_renewed;
        end
        if (w_rd_en) begin
            r_q_exp <= mem_exp[w_raddr];
        end
    end

    // valid bits, config register, read pipe control, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_vld  <= '0;
            r_exp_vld   <= '0;
            r_ttl       <= TTL_RESET;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_ttl <= i_cfg_data;
            end
            if (w_card_we) begin
                r_card_vld[w_widx] <= 1'b1;
            end
            if (w_purge) begin
                r_exp_vld <= '0;
            end else if (w_exp_we) begin
                r_exp_vld[w_widx] <= 1'b1;
            end
            r_rd_v <= w_rd_en && (r_state == ST_SCAN);
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command capture, scan bookkeeping, result payload
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_q_cv   <= r_card_vld[w_raddr];
            r_q_ev   <= r_exp_vld[w_raddr];
            r_rd_idx <= w_raddr;
        end
        if (r_state == ST_SCAN && w_rd_en) begin
            r_addr <= r_addr + CW'(1);
        end
        if (w_in_xfer) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_now      <= i_now;
            r_uid      <= i_card_uid;
            r_flags    <= i_card_flags;
            r_eidx     <= i_entry_index;
            r_in_range <= ({1'b0, i_entry_index} < (IDX_W + 1)'(CAPACITY));
            r_addr     <= '0;
            r_found    <= 1'b0;
            r_free_f   <= 1'b0;
        end else if (r_state == ST_SCAN && r_rd_v) begin
            if (w_match && !r_found) begin
                r_found     <= 1'b1;
                r_hit_idx   <= r_rd_idx;
                r_hit_uid   <= w_card[CARD_W-1:FLAGS_W];
                r_hit_flags <= w_card[FLAGS_W-1:0];
            end
            if (!w_live && !r_free_f) begin
                r_free_f   <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            // strict compare keeps the lowest index on ties
            if ((r_rd_idx == '0) || (w_exp < r_min_exp)) begin
                r_min_exp <= w_exp;
                r_min_idx <= r_rd_idx;
            end
        end
        if (w_finish) begin
            r_o_hit   <= w_n_hit;
            r_o_uid   <= w_n_uid;
            r_o_flags <= w_n_flags;
            r_o_oor   <= w_n_oor;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_hit                = r_o_hit;
    assign o_out_uid            = r_o_uid;
    assign o_out_flags          = r_o_flags;
    assign o_index_out_of_range = r_o_oor;

    // a range error never comes with a card or a hit
    a_oor_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_oor) |-> (!r_o_hit && r_o_uid == '0 && r_o_flags == '0))
        else $error("range error result carries card data");

    // purge leaves no live expiry behind
    a_purge_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_purge |=> (r_exp_vld == '0))
        else $error("expiry valid bits survive purge");

    // the store is written only on the cycle a result is loaded
    a_write_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_card_we || w_exp_we) |-> (w_finish && !w_rd_en))
        else $error("store written outside result load");

    // input is taken only with no scan read in flight
    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |-> (!r_rd_v && !w_rd_en))
        else $error("command taken while memory read pending");

endmodule

[bench/ttl_card_cache_test.sv]
// Testbench for ttl_card_cache: directed and random card commands, checked against
// a behavioural copy of the entry store, with stalls on both channels.
// Depends on ttlc_pkg and the ttl_card_cache RTL.
`timescale 1ns / 100ps

module ttl_card_cache_test;
    import ttlc_pkg::*;

    localparam int unsigned RUN_LIMIT = 500000;
    localparam int unsigned SETTLE    = CAPACITY_D + 8;
    localparam int unsigned POOL_N    = 24;
    localparam int unsigned LONG_HOLD = 400;
    localparam int unsigned IDX_BITS  = $clog2(CAPACITY_D);

    typedef struct packed {
        t_cmd                cmd;
        logic [TIME_W-1:0]   now;
        logic [UID_W-1:0]    uid;
        logic [FLAGS_W-1:0]  flags;
        logic [IDX_W-1:0]    idx;
    } t_card_req;

    typedef struct packed {
        logic                hit;
        logic [UID_W-1:0]    uid;
        logic [FLAGS_W-1:0]  flags;
        logic                oor;
    } t_card_reply;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic [TIME_W-1:0]   i_cfg_data    = '0;
    logic                i_in_valid    = 1'b0;
    logic [1:0]          i_cmd         = '0;
    logic [TIME_W-1:0]   i_now         = '0;
    logic [UID_W-1:0]    i_card_uid    = '0;
    logic [FLAGS_W-1:0]  i_card_flags  = '0;
    logic [IDX_W-1:0]    i_entry_index = '0;
    logic                i_out_ready   = 1'b0;
    logic                o_cfg_ready;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_hit;
    logic [UID_W-1:0]    o_out_uid;
    logic [FLAGS_W-1:0]  o_out_flags;
    logic                o_index_out_of_range;

    ttl_card_cache dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_cmd                (i_cmd),
        .i_now                (i_now),
        .i_card_uid           (i_card_uid),
        .i_card_flags         (i_card_flags),
        .i_entry_index        (i_entry_index),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_hit                (o_hit),
        .o_out_uid            (o_out_uid),
        .o_out_flags          (o_out_flags),
        .o_index_out_of_range (o_index_out_of_range)
    );

    // shadow of the entry store and the TTL register
    logic [UID_W-1:0]    store_uid    [CAPACITY_D] = '{default: '0};
    logic [FLAGS_W-1:0]  store_flags  [CAPACITY_D] = '{default: '0};
    logic [TIME_W-1:0]   store_expiry [CAPACITY_D] = '{default: '0};
    logic [TIME_W-1:0]   ttl_ms = TTL_RESET;

    t_card_req           queued_swipes [$];
    t_card_reply         due_replies   [$];
    logic [UID_W-1:0]    uid_pool [POOL_N];
    logic [TIME_W-1:0]   wall_ms = '0;

    t_card_req           tx_swipe;
    t_card_req           seen_req;
    t_card_reply         want;
    bit                  in_taken = 1'b0;
    bit                  calm = 1'b0;
    int unsigned         tx_gap = 0, rx_gap = 0, rx_hold = 0;
    int unsigned         hold_asks = 0, hold_seen = 0;
    int unsigned         cfg_writes = 0, cycle_count = 0, errors = 0;
    int unsigned         swipes_taken = 0, hits_total = 0, evictions = 0;
    int unsigned         oor_total = 0, purges_total = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Works out the reply to one command and applies it to the shadow store.
    function automatic t_card_reply cache_outcome(input t_card_req rq);
        t_card_reply         r;
        logic [TIME_W-1:0]   renewed;
        int                  slot;
        r = '0;
        renewed = rq.now + ttl_ms;
        slot = -1;
        case (rq.cmd)
            CMD_LOOKUP, CMD_INSERT: begin
                for (int k = 0; k < CAPACITY_D; k++)
                    if (slot < 0 && store_expiry[k] >= rq.now && store_uid[k] == rq.uid)
                        slot = k;
                if (slot >= 0) begin
                    store_expiry[slot] = renewed;
                    r.hit   = 1'b1;
                    r.uid   = store_uid[slot];
                    r.flags = store_flags[slot];
                    hits_total++;
                end else if (rq.cmd == CMD_INSERT) begin
                    for (int k = 0; k < CAPACITY_D; k++)
                        if (slot < 0 && store_expiry[k] < rq.now)
                            slot = k;
                    if (slot < 0) begin
                        // all live: oldest expiry goes, lowest index on ties
                        slot = 0;
                        for (int k = 1; k < CAPACITY_D; k++)
                            if (store_expiry[k] < store_expiry[slot])
                                slot = k;
                        evictions++;
                    end
                    store_uid[slot]    = rq.uid;
                    store_flags[slot]  = rq.flags;
                    store_expiry[slot] = renewed;
                end
            end
            CMD_PURGE: begin
                for (int k = 0; k < CAPACITY_D; k++)
                    store_expiry[k] = '0;
                purges_total++;
            end
            default: begin
                if (rq.idx < CAPACITY_D) begin
                    r.uid   = store_uid[rq.idx[IDX_BITS-1:0]];
                    r.flags = store_flags[rq.idx[IDX_BITS-1:0]];
                end else begin
                    r.oor = 1'b1;
                    oor_total++;
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_card_req random_swipe();
        t_card_req    rq;
        int unsigned  pick;
        pick = $urandom_range(0, 99);
        if (pick >= 96)
            wall_ms = $urandom;
        else if (pick >= 80)
            wall_ms += $urandom_range(26, 3000);
        else if (pick >= 25)
            wall_ms += $urandom_range(1, 25);
        // occasional stray timestamp, possibly running backwards
        rq.now = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : wall_ms;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            rq.cmd = CMD_LOOKUP;
        else if (pick < 80)
            rq.cmd = CMD_INSERT;
        else if (pick < 85)
            rq.cmd = CMD_PURGE;
        else
            rq.cmd = CMD_READ;
        rq.uid = ($urandom_range(0, 6) == 0) ? UID_W'({$urandom, $urandom})
                                             : uid_pool[$urandom_range(0, POOL_N - 1)];
        rq.flags = FLAGS_W'($urandom_range(0, 3));
        rq.idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 255))
                                             : IDX_W'($urandom_range(0, CAPACITY_D - 1));
        return rq;
    endfunction

    task automatic push_swipe(input t_cmd cmd, input logic [TIME_W-1:0] now,
                              input logic [UID_W-1:0] uid, input logic [FLAGS_W-1:0] flags,
                              input logic [IDX_W-1:0] idx);
        queued_swipes.push_back('{cmd: cmd, now: now, uid: uid, flags: flags, idx: idx});
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count) queued_swipes.push_back(random_swipe());
    endtask

    // Wait until every command has gone through and its reply has come back.
    task automatic settle();
        do begin
            @(posedge i_clk);
            #2;
        end while (queued_swipes.size() != 0 || i_in_valid || due_replies.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
        #2;
    endtask

    task automatic write_ttl(input logic [TIME_W-1:0] value);
        int unsigned prior;
        settle();
        prior = cfg_writes;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
            #2;
        end while (cfg_writes == prior);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        #2;
    endtask

    task automatic compare_field(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
        end
    endtask

    // command sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // offer held until the transfer
        end else if (tx_gap > 0) begin
            tx_gap--;
            i_in_valid <= 1'b0;
        end else if (queued_swipes.size() == 0) begin
            i_in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            tx_gap = $urandom_range(0, 10);
            i_in_valid <= 1'b0;
        end else begin
            tx_swipe = queued_swipes.pop_front();
            i_cmd         <= tx_swipe.cmd;
            i_now         <= tx_swipe.now;
            i_card_uid    <= tx_swipe.uid;
            i_card_flags  <= tx_swipe.flags;
            i_entry_index <= tx_swipe.idx;
            i_in_valid    <= 1'b1;
        end
    end

    // reply receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_seen != hold_asks) begin
            hold_seen++;
            rx_hold = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: predicts on command transfers, checks on reply transfers
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("Timed out after %0d cycles, %0d replies outstanding",
                     cycle_count, due_replies.size());
            $display("FAIL ttl_card_cache");
            $finish;
        end
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (due_replies.size() == 0) begin
                    errors++;
                    $display("%0t ns: reply with none outstanding, expected nothing, got %0h %0h",
                             $time, o_out_uid, o_out_flags);
                end else begin
                    want = due_replies.pop_front();
                    compare_field("hit", 64'(want.hit), 64'(o_hit));
                    compare_field("uid", 64'(want.uid), 64'(o_out_uid));
                    compare_field("flags", 64'(want.flags), 64'(o_out_flags));
                    compare_field("range flag", 64'(want.oor), 64'(o_index_out_of_range));
                end
            end
            if (i_in_valid && o_in_ready) begin
                seen_req = '{cmd: t_cmd'(i_cmd), now: i_now, uid: i_card_uid,
                             flags: i_card_flags, idx: i_entry_index};
                due_replies.push_back(cache_outcome(seen_req));
                in_taken = 1'b1;
                swipes_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                ttl_ms = i_cfg_data;
                cfg_writes++;
            end
        end
    end

    initial begin
        uid_pool[0] = '0;
        uid_pool[1] = {UID_W{1'b1}};
        for (int k = 2; k < POOL_N; k++)
            uid_pool[k] = UID_W'({$urandom, $urandom});
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #2;

        // directed: fresh store, range edges, renewals, purge and time wrap
        push_swipe(CMD_READ,   '0, '0, '0, '0);
        push_swipe(CMD_READ,   '0, '0, '0, IDX_W'(CAPACITY_D - 1));
        push_swipe(CMD_READ,   '0, '0, '0, IDX_W'(CAPACITY_D));
        push_swipe(CMD_READ,   '0, '0, '0, 8'hFF);
        push_swipe(CMD_LOOKUP, '0, '0, '0, '0);
        push_swipe(CMD_INSERT, 32'd5, uid_pool[1], 2'b11, '0);
        push_swipe(CMD_LOOKUP, 32'd5, uid_pool[1], '0, '0);
        push_swipe(CMD_INSERT, 32'd6, uid_pool[1], 2'b00, '0);
        push_swipe(CMD_INSERT, 32'd7, uid_pool[2], 2'b01, '0);
        push_swipe(CMD_READ,   32'd7, '0, '0, 8'd1);
        push_swipe(CMD_PURGE,  32'd8, uid_pool[2], 2'b11, 8'hAA);
        push_swipe(CMD_LOOKUP, 32'd9, uid_pool[1], '0, '0);
        push_swipe(CMD_LOOKUP, '0, '0, '0, '0);
        push_swipe(CMD_INSERT, 32'hFFFF_FFFF, uid_pool[3], 2'b10, '0);
        push_swipe(CMD_LOOKUP, 32'hFFFF_FFFF, uid_pool[3], '0, '0);
        push_swipe(CMD_READ,   32'hFFFF_FFFF, '0, '0, '0);
        settle();

        run_random(180);
        write_ttl('0);
        run_random(120);
        write_ttl('1);
        run_random(100);
        write_ttl(32'd40);
        run_random(90);
        hold_asks++;
        settle();
        run_random(90);
        write_ttl($urandom);
        run_random(150);
        write_ttl(32'd1000);
        wall_ms = 32'hFFFF_F800;
        run_random(150);
        write_ttl(TTL_RESET);
        calm = 1'b1;
        run_random(250);

        settle();
        repeat (40) @(posedge i_clk);
        #2;
        $display("Ran %0d commands under 7 TTL settings, including zero and all ones:",
                 swipes_taken);
        $display("  %0d hits, %0d live evictions, %0d out-of-range reads, %0d purges",
                 hits_total, evictions, oor_total, purges_total);
        if (errors == 0) begin
            $display("PASS ttl_card_cache");
        end else begin
            $display("FAIL ttl_card_cache");
        end
        $finish;
    end

endmodule
